FILE: src/rsf_pkg.sv
// rsf_pkg: shared types and constants of the run-length sprite pixel fetch
// used by rsf_step and rle_sprite_pixel_fetch; no dependencies
package rsf_pkg;

    localparam int BYTE_W    = 8;
    localparam int COL_W     = 10;
    localparam int DIM_W     = 11;
    localparam int CNT_COL_W = 11;
    localparam int LIT_W     = 7;
    localparam int STATUS_W  = 2;
    localparam int CMP_W     = 17;
    localparam int CFG_IDX_W = 3;
    localparam int TDATA_M_W = 16;

    localparam logic [BYTE_W-1:0]    RUN_TRANSPARENT = 8'h80;
    localparam logic [LIT_W-1:0]     RUN_MASK        = 7'h7F;
    localparam logic [CNT_COL_W-1:0] COL_MAX         = 11'h7FF;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_FOUND        = 2'd0,
        STATUS_OUT_OF_RANGE = 2'd1,
        STATUS_INCONSISTENT = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_COL   = 3'd0,
        REG_TARGET_ROW   = 3'd1,
        REG_IMAGE_WIDTH  = 3'd2,
        REG_IMAGE_HEIGHT = 3'd3
    } reg_index_t;

    typedef struct packed {
        logic [COL_W-1:0] target_col;
        logic [COL_W-1:0] target_row;
        logic [DIM_W-1:0] image_width;
        logic [DIM_W-1:0] image_height;
    } cfg_t;

    typedef struct packed {
        logic              emit;
        logic [BYTE_W-1:0] pixel_index;
        status_t           status;
    } step_result_t;

endpackage

FILE: src/rsf_step.sv
// rsf_step: row/column walk state and the decode of one stream byte
// depends on rsf_pkg
module rsf_step #(
    parameter int MAX_DIM = 1024
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       advance,
    input  logic [rsf_pkg::BYTE_W-1:0] data_byte,
    input  logic                       first_byte,
    input  rsf_pkg::cfg_t              cfg,
    output rsf_pkg::step_result_t      result,
    output logic                       search_idle
);

    logic [rsf_pkg::COL_W-1:0]     row_count_reg, row_count_next;
    logic [rsf_pkg::CNT_COL_W-1:0] col_count_reg, col_count_next;
    logic [rsf_pkg::LIT_W-1:0]     literal_left_reg, literal_left_next;
    logic                          search_done_reg, search_done_next;

    logic [rsf_pkg::COL_W-1:0]     rc;
    logic [rsf_pkg::CNT_COL_W-1:0] cc;
    logic [rsf_pkg::LIT_W-1:0]     ll;
    logic                          sd;
    logic [rsf_pkg::CMP_W-1:0]     width_ext, height_ext, width_lim, height_lim;
    logic                          out_of_range;
    logic                          on_row;
    logic [rsf_pkg::LIT_W-1:0]     run_len;
    logic [rsf_pkg::CNT_COL_W:0]   run_end;

    assign width_ext  = rsf_pkg::CMP_W'(cfg.image_width);
    assign height_ext = rsf_pkg::CMP_W'(cfg.image_height);
    assign width_lim  = (width_ext > rsf_pkg::CMP_W'(MAX_DIM)) ?
                        rsf_pkg::CMP_W'(MAX_DIM) : width_ext;
    assign height_lim = (height_ext > rsf_pkg::CMP_W'(MAX_DIM)) ?
                        rsf_pkg::CMP_W'(MAX_DIM) : height_ext;
    assign out_of_range = (rsf_pkg::CMP_W'(cfg.target_col) >= width_lim) ||
                          (rsf_pkg::CMP_W'(cfg.target_row) >= height_lim);

    assign rc = first_byte ? '0 : row_count_reg;
    assign cc = first_byte ? '0 : col_count_reg;
    assign ll = first_byte ? '0 : literal_left_reg;
    assign sd = first_byte ? 1'b0 : search_done_reg;

    assign on_row  = (rc == cfg.target_row);
    assign run_len = data_byte[rsf_pkg::LIT_W-1:0] & rsf_pkg::RUN_MASK;
    assign run_end = {1'b0, cc} + (rsf_pkg::CNT_COL_W+1)'(run_len);

    always_comb begin
        row_count_next     = rc;
        col_count_next     = cc;
        literal_left_next  = ll;
        search_done_next   = sd;
        result.emit        = 1'b0;
        result.pixel_index = '0;
        result.status      = rsf_pkg::STATUS_FOUND;
        if (first_byte && out_of_range) begin
            result.emit      = 1'b1;
            result.status    = rsf_pkg::STATUS_OUT_OF_RANGE;
            search_done_next = 1'b1;
        end else if (!sd) begin
            if (ll != '0) begin
                // pixel byte of a literal run
                if (on_row && (cc == rsf_pkg::CNT_COL_W'(cfg.target_col))) begin
                    result.emit        = 1'b1;
                    result.pixel_index = data_byte;
                    search_done_next   = 1'b1;
                end else begin
                    literal_left_next = ll - 1'b1;
                    if (cc != rsf_pkg::COL_MAX) begin
                        col_count_next = cc + 1'b1;
                    end
                end
            end else if (data_byte == '0) begin
                // end of row
                if (on_row) begin
                    result.emit      = 1'b1;
                    result.status    = rsf_pkg::STATUS_INCONSISTENT;
                    search_done_next = 1'b1;
                end else begin
                    row_count_next = rc + 1'b1;
                    col_count_next = '0;
                end
            end else if ((data_byte & rsf_pkg::RUN_TRANSPARENT) != '0) begin
                if (on_row && (run_end > (rsf_pkg::CNT_COL_W+1)'(cfg.target_col))) begin
                    result.emit      = 1'b1;
                    search_done_next = 1'b1;
                end else if (run_end[rsf_pkg::CNT_COL_W]) begin
                    col_count_next = rsf_pkg::COL_MAX;
                end else begin
                    col_count_next = run_end[rsf_pkg::CNT_COL_W-1:0];
                end
            end else begin
                literal_left_next = run_len;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg    <= '0;
            col_count_reg    <= '0;
            literal_left_reg <= '0;
            search_done_reg  <= 1'b1;
        end else if (advance) begin
            row_count_reg    <= row_count_next;
            col_count_reg    <= col_count_next;
            literal_left_reg <= literal_left_next;
            search_done_reg  <= search_done_next;
        end
    end

    assign search_idle = search_done_reg;

endmodule

FILE: src/rle_sprite_pixel_fetch.sv
// rle_sprite_pixel_fetch: top level, input register, config registers, result register
// depends on rsf_pkg and rsf_step
//
// channel  direction  payload
// s_       in         tdata = data_byte, tuser = first_byte
// m_       out        tdata = pixel_index, status
// cfg_     in         index = register number, data = register value
//
// one stream byte per cycle while the result register is not stalled; a request
// taken into the input register is decoded against the walk state and any result
// is loaded into the result register, which drives m_tvalid.
// while the result register holds an untaken result, the input register holds its
// byte and s_tready drops once both are full. reset (aresetn low) clears the walk
// state and leaves the block idle until a first byte arrives.
module rle_sprite_pixel_fetch #(
    parameter int MAX_DIM = 1024
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [rsf_pkg::BYTE_W-1:0]           s_tdata,   // data_byte[7:0]
    input  logic                                 s_tuser,   // first_byte[0]
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [rsf_pkg::TDATA_M_W-1:0]        m_tdata,   // pixel_index[7:0], status[9:8]
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [rsf_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [rsf_pkg::DIM_W-1:0]            cfg_data
);

    rsf_pkg::cfg_t cfg_reg;

    logic                        in_vld_reg;
    logic [rsf_pkg::BYTE_W-1:0]  in_byte_reg;
    logic                        in_first_reg;
    logic                        out_vld_reg;
    logic [rsf_pkg::BYTE_W-1:0]  out_pix_reg;
    rsf_pkg::status_t            out_status_reg;
    logic                        advance;
    logic                        search_idle;
    rsf_pkg::step_result_t       step_res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                rsf_pkg::REG_TARGET_COL:   cfg_reg.target_col   <= cfg_data[rsf_pkg::COL_W-1:0];
                rsf_pkg::REG_TARGET_ROW:   cfg_reg.target_row   <= cfg_data[rsf_pkg::COL_W-1:0];
                rsf_pkg::REG_IMAGE_WIDTH:  cfg_reg.image_width  <= cfg_data;
                rsf_pkg::REG_IMAGE_HEIGHT: cfg_reg.image_height <= cfg_data;
                default: ;
            endcase
        end
    end

    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg  <= s_tdata;
            in_first_reg <= s_tuser;
        end
    end

    rsf_step #(
        .MAX_DIM (MAX_DIM)
    ) u_step (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .data_byte   (in_byte_reg),
        .first_byte  (in_first_reg),
        .cfg         (cfg_reg),
        .result      (step_res),
        .search_idle (search_idle)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (!out_vld_reg || m_tready) begin
            out_vld_reg <= advance && step_res.emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && step_res.emit) begin
            out_pix_reg    <= step_res.pixel_index;
            out_status_reg <= step_res.status;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {6'b0, out_status_reg, out_pix_reg};

    // a result leaves the walk idle
    a_emit_idles: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && step_res.emit |=> search_idle)
        else $error("walk not idle after result");

    // no result while idle unless a first byte restarts the search
    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && step_res.emit |-> (!search_idle || in_first_reg))
        else $error("result from idle walk");

    // an empty input register always takes a request
    a_in_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_vld_reg |-> s_tready)
        else $error("input stalled while empty");

    // a result only leaves when taken
    a_out_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(out_vld_reg) |-> $past(m_tready))
        else $error("result dropped");

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// tb: self-checking bench for rle_sprite_pixel_fetch, walks run-length sprite streams
// and checks each result against a behavioral walk of the same bytes or a table row
// depends on rsf_pkg and rle_sprite_pixel_fetch
module tb;
    import rsf_pkg::*;

    localparam int MAX_DIM     = 1024;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYC  = 4;
    localparam int HOLD_CYC    = 300;
    localparam int WORK_ITEMS  = 900;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd5;
    localparam logic [DIM_W-1:0] DIM_EDGE [4] = '{11'd0, 11'd1, 11'd1024, 11'd2047};

    typedef struct packed {
        logic [BYTE_W-1:0] pixel;
        status_t           status;
    } fetch_t;

    typedef enum bit {ROW_BYTE, ROW_CFG} row_kind_t;
    typedef enum logic [1:0] {EXP_PRED, EXP_NONE, EXP_TYPED} exp_kind_t;
    typedef enum logic [1:0] {FRAME_CLEAN, FRAME_BROKEN, FRAME_NOISE} frame_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [DIM_W-1:0]      value;
        logic [BYTE_W-1:0]     data;
        logic                  first;
        exp_kind_t             how;
        logic [BYTE_W-1:0]     t_pix;
        status_t               t_st;
    } stim_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [BYTE_W-1:0] s_tdata = '0;        // data_byte[7:0]
    logic s_tuser = 1'b0;                   // first_byte[0]
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [TDATA_M_W-1:0] m_tdata;          // pixel_index[7:0], status[9:8]
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0] cfg_data = '0;

    // walk state and register copy
    cfg_t cur = '0;
    logic [COL_W-1:0] row_cnt = '0;
    logic [CNT_COL_W-1:0] col_cnt = '0;
    logic [LIT_W-1:0] lit_left = '0;
    bit walk_idle = 1'b1;

    fetch_t pending_pix[$];
    fetch_t rx_want;
    int fails = 0;
    int pix_checked = 0;
    int bytes_sent = 0;
    int work_cnt = 0;
    int cfg_writes = 0;
    int cycle_cnt = 0;
    int hold_asked = 0;
    int hold_served = 0;
    int hold_left = 0;
    bit steady = 1'b0;

    stim_row_t dir_tbl [30] = '{
        '{ROW_BYTE, REG_UNUSED, 11'd0, 8'h05, 1'b0, EXP_NONE, 8'h00, STATUS_FOUND},
        '{ROW_BYTE, REG_UNUSED, 11'd0, 8'h00, 1'b1, EXP_TYPED, 8'h00, STATUS_OUT_OF_RANGE},
        '{ROW_CFG, REG_TARGET_COL, 11'd2, 8'h00, 1'b0, EXP_NONE, 8'h00, STATUS_FOUND},
        '{ROW_CFG, REG_TARGET_ROW, 11'd1, 8'h00, 1'b0, EXP_NONE, 8'h00, STATUS_FOUND},
        '{ROW_CFG, REG_IMAGE_WIDTH, 11'd4, 8'h00, 1'b0, EXP_NONE, 8'h00, STATUS_FOUND},
        '{ROW_CFG, REG_IMAGE_HEIGHT, 11'd3, 8'h00, 1'b0, EXP_NONE, 8'h00, STATUS_FOUND},
        '{ROW_BYTE, REG_UNUSED, 11'd0, 8'h82, 1'b1, EXP_PRED, 8'h00, STATUS_FOUND},
        '{ROW_BYTE, REG_UNUSED, 11'd0, 8'h00, 1'b0, EXP_PRED, 8'h00, STATUS_FOUND},
        '{ROW_BYTE, REG_UNUSED, 11'd0, 8'h03, 1'b0, EXP_PRED, 8'h00, STATUS_FOUND},
        '{ROW_BYTE, REG_UNUSED, 11'd0, 8'h11, 1'b0, EXP_PRED, 8'h00, STATUS_FOUND},
        '{ROW_BYTE, REG_UNUSED, 11'd0, 8'h22, 1'b0, EXP_PRED, 8'h00, STATUS_FOUND},
        '{ROW_BYTE, REG_UNUSED, 11'd0, 8'hFF, 1'b0, EXP_PRED, 8'h00, STATUS_FOUND},
        '{ROW_BYTE, REG_UNUSED, 11'd0, 8'h44, 1'b0, EXP_NONE, 8'h00, STATUS_FOUND},
        '{ROW_BYTE, REG_UNUSED, 11'd0, 8'h00, 1'b1, EXP_PRED, 8'h00, STATUS_FOUND},
        '{ROW_BYTE, REG_UNUSED, 11'd0, 8'h80, 1'b0, EXP_PRED, 8'h00, STATUS_FOUND},
        '{ROW_BYTE, REG_UNUSED, 11'd0, 8'h00, 1'b0, EXP_TYPED, 8'h00, STATUS_INCONSISTENT},
        '{ROW_BYTE, REG_UNUSED, 11'd0, 8'h00, 1'b1, EXP_PRED, 8'h00, STATUS_FOUND},
        '{ROW_BYTE, REG_UNUSED, 11'd0, 8'h81, 1'b0, EXP_PRED, 8'h00, STATUS_FOUND},
        '{ROW_BYTE, REG_UNUSED, 11'd0, 8'hFF, 1'b0, EXP_PRED, 8'h00, STATUS_FOUND},
        '{ROW_CFG, REG_TARGET_COL, 11'h7FF, 8'h00, 1'b0, EXP_NONE, 8'h00, STATUS_FOUND},
        '{ROW_CFG, REG_TARGET_ROW, 11'h3FF, 8'h00, 1'b0, EXP_NONE, 8'h00, STATUS_FOUND},
        '{ROW_CFG, REG_IMAGE_WIDTH, 11'h7FF, 8'h00, 1'b0, EXP_NONE, 8'h00, STATUS_FOUND},
        '{ROW_CFG, REG_IMAGE_HEIGHT, 11'h3FF, 8'h00, 1'b0, EXP_NONE, 8'h00, STATUS_FOUND},
        '{ROW_BYTE, REG_UNUSED, 11'd0, 8'h7F, 1'b1, EXP_TYPED, 8'h00, STATUS_OUT_OF_RANGE},
        '{ROW_CFG, REG_IMAGE_HEIGHT, 11'h400, 8'h00, 1'b0, EXP_NONE, 8'h00, STATUS_FOUND},
        '{ROW_CFG, REG_UNUSED, 11'h7FF, 8'h00, 1'b0, EXP_NONE, 8'h00, STATUS_FOUND},
        '{ROW_BYTE, REG_UNUSED, 11'd0, 8'hFF, 1'b1, EXP_PRED, 8'h00, STATUS_FOUND},
        '{ROW_BYTE, REG_UNUSED, 11'd0, 8'h7F, 1'b0, EXP_PRED, 8'h00, STATUS_FOUND},
        '{ROW_BYTE, REG_UNUSED, 11'd0, 8'h01, 1'b1, EXP_PRED, 8'h00, STATUS_FOUND},
        '{ROW_BYTE, REG_UNUSED, 11'd0, 8'h80, 1'b0, EXP_PRED, 8'h00, STATUS_FOUND}
    };

    rle_sprite_pixel_fetch #(.MAX_DIM(MAX_DIM)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    // one byte of the sprite walk; returns 1 when the byte yields a pixel result
    function automatic bit walk_byte(input logic [BYTE_W-1:0] b, input logic f,
                                     output fetch_t r);
        int wlim;
        int hlim;
        int n;
        bit on_row;
        r.pixel = '0;
        r.status = STATUS_FOUND;
        if (f) begin
            row_cnt = '0;
            col_cnt = '0;
            lit_left = '0;
            walk_idle = 1'b0;
            wlim = (cur.image_width > MAX_DIM) ? MAX_DIM : int'(cur.image_width);
            hlim = (cur.image_height > MAX_DIM) ? MAX_DIM : int'(cur.image_height);
            if (int'(cur.target_col) >= wlim || int'(cur.target_row) >= hlim) begin
                r.status = STATUS_OUT_OF_RANGE;
                walk_idle = 1'b1;
                return 1'b1;
            end
        end
        if (walk_idle)
            return 1'b0;
        on_row = (row_cnt == cur.target_row);
        if (lit_left != '0) begin
            if (on_row && col_cnt == cur.target_col) begin
                r.pixel = b;
                walk_idle = 1'b1;
                return 1'b1;
            end
            lit_left = lit_left - 1'b1;
            if (col_cnt < COL_MAX)
                col_cnt = col_cnt + 1'b1;
            return 1'b0;
        end
        if (b == 8'h00) begin
            if (on_row) begin
                r.status = STATUS_INCONSISTENT;
                walk_idle = 1'b1;
                return 1'b1;
            end
            row_cnt = row_cnt + 1'b1;
            col_cnt = '0;
            return 1'b0;
        end
        n = int'(b[LIT_W-1:0] & RUN_MASK);
        if ((b & RUN_TRANSPARENT) != '0) begin
            if (on_row && int'(col_cnt) + n > int'(cur.target_col)) begin
                walk_idle = 1'b1;
                return 1'b1;
            end
            n = int'(col_cnt) + n;
            col_cnt = (n > int'(COL_MAX)) ? COL_MAX : CNT_COL_W'(n);
            return 1'b0;
        end
        lit_left = b[LIT_W-1:0] & RUN_MASK;
        return 1'b0;
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic f,
                             input exp_kind_t how = EXP_PRED, input fetch_t typed = '0);
        fetch_t r;
        bit hit;
        cfg_valid <= 1'b0;
        while (!steady && $urandom_range(0, 99) < 16) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= f;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
        if (f || !walk_idle)
            work_cnt++;
        hit = walk_byte(b, f, r);
        case (how)
            EXP_PRED:  if (hit) pending_pix.push_back(r);
            EXP_TYPED: pending_pix.push_back(typed);
            default: ;
        endcase
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_writes++;
        case (idx)
            REG_TARGET_COL:   cur.target_col = v[COL_W-1:0];
            REG_TARGET_ROW:   cur.target_row = v[COL_W-1:0];
            REG_IMAGE_WIDTH:  cur.image_width = v;
            REG_IMAGE_HEIGHT: cur.image_height = v;
            default: ;
        endcase
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        cfg_valid <= 1'b0;
        do @(posedge aclk); while (pending_pix.size() != 0);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    // rows of runs up to the image width until the search ends; or 40 noise bytes
    task automatic send_frame(input frame_kind_t kind);
        int w;
        int h;
        int left;
        int n;
        int r;
        int k;
        bit cut;
        bit lead;
        lead = 1'b1;
        w = (cur.image_width > MAX_DIM) ? MAX_DIM : int'(cur.image_width);
        h = (cur.image_height > MAX_DIM) ? MAX_DIM : int'(cur.image_height);
        if (h == 0)
            h = 1;
        if (kind == FRAME_NOISE) begin
            for (k = 0; k < 40; k++)
                send_byte(8'($urandom_range(0, 255)), (k == 0) || ($urandom_range(0, 19) == 0));
            return;
        end
        for (r = 0; r < h && (lead || !walk_idle); r++) begin
            left = w;
            cut = (kind == FRAME_BROKEN) && ($urandom_range(0, 3) == 0);
            while (left > 0 && (lead || !walk_idle)) begin
                if (cut && $urandom_range(0, 2) == 0)
                    break;
                if ($urandom_range(0, 15) == 0) begin
                    send_byte(RUN_TRANSPARENT, lead);
                    lead = 1'b0;
                end
                n = $urandom_range(1, (left > 127) ? 127 : left);
                if ($urandom_range(0, 1) == 0) begin
                    send_byte(RUN_TRANSPARENT | 8'(n), lead);
                    lead = 1'b0;
                end else begin
                    if (w > 64 && n > 8)
                        n = $urandom_range(1, 8);
                    send_byte(8'(n), lead);
                    lead = 1'b0;
                    for (k = 0; k < n && !walk_idle; k++)
                        send_byte(8'($urandom_range(0, 255)), 1'b0);
                end
                left -= n;
            end
            // overlong row pushes the column counter into saturation
            if (kind == FRAME_BROKEN && $urandom_range(0, 4) == 0) begin
                repeat (17) begin
                    if (lead || !walk_idle) begin
                        send_byte(8'hFF, lead);
                        lead = 1'b0;
                    end
                end
            end
            if (lead || !walk_idle) begin
                send_byte(8'h00, lead);
                lead = 1'b0;
            end
        end
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    // result side: check, then pick tready for the next cycle
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_pix.size() == 0) begin
                $error("result with none pending: pixel_index=%0d status=%0d",
                       m_tdata[7:0], m_tdata[9:8]);
                fails++;
            end else begin
                rx_want = pending_pix.pop_front();
                pix_checked++;
                if (m_tdata[7:0] !== rx_want.pixel) begin
                    $error("pixel_index: expected %0d, got %0d", rx_want.pixel, m_tdata[7:0]);
                    fails++;
                end
                if (m_tdata[9:8] !== rx_want.status) begin
                    $error("status: expected %0d, got %0d", rx_want.status, m_tdata[9:8]);
                    fails++;
                end
                if (m_tdata[TDATA_M_W-1:10] !== '0) begin
                    $error("tdata pad: expected 0, got %0h", m_tdata[TDATA_M_W-1:10]);
                    fails++;
                end
            end
        end
        if (hold_left != 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_asked) begin
            hold_served <= hold_asked;
            hold_left <= HOLD_CYC;
            m_tready <= 1'b0;
        end else begin
            m_tready <= steady || ($urandom_range(0, 99) >= 16);
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $error("timeout after %0d cycles, %0d results pending",
                   cycle_cnt, pending_pix.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int i;
        int phase;
        int mode;
        int k;
        logic [DIM_W-1:0] tc;
        logic [DIM_W-1:0] tr;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        fetch_t tv;
        phase = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        for (i = 0; i < $size(dir_tbl); i++) begin
            if (dir_tbl[i].kind == ROW_CFG) begin
                if (i == 0 || dir_tbl[i-1].kind != ROW_CFG)
                    drain_results();
                cfg_write(dir_tbl[i].idx, dir_tbl[i].value);
            end else begin
                tv.pixel = dir_tbl[i].t_pix;
                tv.status = dir_tbl[i].t_st;
                send_byte(dir_tbl[i].data, dir_tbl[i].first, dir_tbl[i].how, tv);
            end
        end

        work_cnt = 0;
        while (work_cnt < WORK_ITEMS) begin
            phase++;
            drain_results();
            steady = (phase >= 4 && phase < 8);
            if (phase == 2)
                hold_asked++;
            mode = $urandom_range(0, 9);
            if (mode == 0) begin
                k = $urandom_range(0, 2);
                tc = (k == 0) ? 11'd0 : (k == 1) ? 11'd1023 : 11'($urandom_range(0, 2047));
                tr = $urandom_range(0, 1) ? 11'd1023 : 11'd0;
                w = DIM_EDGE[$urandom_range(0, 3)];
                if (tr == 11'd1023)
                    h = DIM_EDGE[$urandom_range(0, 1)] | (($urandom_range(0, 2) == 0) ?
                        11'd1023 : 11'd0);
                else
                    h = DIM_EDGE[$urandom_range(0, 3)];
            end else if (mode == 1) begin
                w = 11'd1024;
                h = 11'd2;
                tc = 11'($urandom_range(0, 1023));
                tr = 11'($urandom_range(0, 1));
            end else begin
                w = 11'($urandom_range(1, 24));
                h = 11'($urandom_range(1, 6));
                tc = ($urandom_range(0, 9) == 0) ? w + 11'($urandom_range(0, 3)) :
                     11'($urandom_range(0, int'(w) - 1));
                tr = ($urandom_range(0, 9) == 0) ? h : 11'($urandom_range(0, int'(h) - 1));
            end
            cfg_write(REG_TARGET_COL, tc);
            cfg_write(REG_TARGET_ROW, tr);
            cfg_write(REG_IMAGE_WIDTH, w);
            cfg_write(REG_IMAGE_HEIGHT, h);
            if ($urandom_range(0, 9) == 0)
                cfg_write(REG_UNUSED, 11'($urandom_range(0, 2047)));
            repeat ($urandom_range(2, 6)) begin
                k = $urandom_range(0, 99);
                send_frame((k < 70) ? FRAME_CLEAN : (k < 85) ? FRAME_BROKEN : FRAME_NOISE);
            end
        end

        steady = 1'b0;
        drain_results();
        repeat (8) @(posedge aclk);
        $display("run: %0d bytes, %0d pixel results checked, %0d register writes",
                 bytes_sent, pix_checked, cfg_writes);
        $display("run: %0d random phases, saturation, early row end, out of range",
                 phase);
        if (fails == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
